[hdl/utc_ets_pkg.sv]
// ----------------------------------------------------------------------------
// UTC epoch timestamp converter package
// Shared transfer types, calendar constants and the month length table.
// ----------------------------------------------------------------------------
package utc_ets_pkg;

	// Field widths
	localparam int unsigned YEAR_W   = 12;
	localparam int unsigned FACTOR_W = 30;
	localparam int unsigned PADDR_W  = 3;

	// Item kinds
	localparam logic REQ_UTC   = 1'b0;
	localparam logic REQ_STAMP = 1'b1;

	// Register index taken from the word address bit
	localparam logic REG_IDX_USE_DEVICE_TIME = 1'b0;

	// Calendar constants
	localparam int unsigned FIRST_YEAR   = 1970;
	localparam int unsigned DAYS_LEAP    = 366;
	localparam logic [YEAR_W-1:0] FIRST_YEAR_Y = 12'd1970;
	localparam logic [3:0] MONTH_JAN = 4'd1;
	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_DEC = 4'd12;
	localparam logic [8:0] DAYS_PER_YEAR = 9'd365;
	localparam logic [8:0] DAYS_PER_LEAP = 9'd366;

	// Residues of 1970 for the leap year counters
	localparam logic [1:0] FIRST_MOD4   = 2'd2;
	localparam logic [6:0] FIRST_MOD100 = 7'd70;
	localparam logic [8:0] FIRST_MOD400 = 9'd370;
	localparam logic [6:0] LAST_MOD100  = 7'd99;
	localparam logic [8:0] LAST_MOD400  = 9'd399;

	// Scale factors of the time chain
	localparam logic [FACTOR_W-1:0] HOURS_PER_DAY = 30'd24;
	localparam logic [FACTOR_W-1:0] MIN_PER_HOUR  = 30'd60;
	localparam logic [FACTOR_W-1:0] SEC_PER_MIN   = 30'd60;
	localparam logic [FACTOR_W-1:0] NS_PER_SEC    = 30'd1000000000;
	localparam logic [FACTOR_W-1:0] NS_PER_US     = 30'd1000;

	// Input item
	typedef struct packed {
		logic              req_type;
		logic [YEAR_W-1:0] year;
		logic [3:0]        month;
		logic [4:0]        day;
		logic [4:0]        hour;
		logic [5:0]        minute;
		logic [5:0]        second;
		logic [29:0]       nanosecond;
		logic              clock_valid;
		logic [31:0]       dev_time_us;
	} req_t;

	// Result item
	typedef struct packed {
		logic [63:0] epoch_ns;
		logic        stamp_valid;
		logic        utc_error;
	} rsp_t;

	// Multiply-add request: result = operand * factor + addend, modulo 2^64
	typedef struct packed {
		logic                start;
		logic [63:0]         operand;
		logic [FACTOR_W-1:0] factor;
		logic [63:0]         addend;
	} mac_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] result;
	} mac_rsp_t;

	// Days in a month of a common year
	function automatic logic [4:0] month_days(input logic [3:0] m);
		logic [4:0] d;
		case (m)
			4'd2:    d = 5'd28;
			4'd4:    d = 5'd30;
			4'd6:    d = 5'd30;
			4'd9:    d = 5'd30;
			4'd11:   d = 5'd30;
			default: d = 5'd31;
		endcase
		return d;
	endfunction

endpackage

[hdl/utc_epoch_timestamp_converter.sv]
// ----------------------------------------------------------------------------
// UTC epoch timestamp converter
// Turns UTC reference dates into Unix epoch nanoseconds and stamps device
// timestamps against the stored reference.
// ----------------------------------------------------------------------------
// One item is in work at a time and every item gives exactly one result.
// In a UTC reference update, with year and month clamped to their ranges,
// the year walk adds one year per cycle, the month walk one month per
// cycle, and the four steps of the hour/minute/second/nanosecond chain each
// run on the shared multiply-add unit. A device timestamp item takes one
// multiply-add step, a rejected or system clock item none.
// The next item is taken while the previous result waits in the output
// register; a finished item then holds until the output register frees.
module utc_epoch_timestamp_converter #(
	parameter int unsigned LAST_YEAR = 2099
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  utc_ets_pkg::req_t               req,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output utc_ets_pkg::rsp_t               rsp,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [utc_ets_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	localparam int unsigned DAYS_W = $clog2((LAST_YEAR - utc_ets_pkg::FIRST_YEAR + 1)
		* utc_ets_pkg::DAYS_LEAP + 1);
	localparam logic [utc_ets_pkg::YEAR_W-1:0] LAST_YEAR_Y = utc_ets_pkg::YEAR_W'(LAST_YEAR);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_YEAR    = 3'd1;
	localparam logic [2:0] ST_MONTH   = 3'd2;
	localparam logic [2:0] ST_DAYADD  = 3'd3;
	localparam logic [2:0] ST_MACGO   = 3'd4;
	localparam logic [2:0] ST_MACWAIT = 3'd5;
	localparam logic [2:0] ST_DONE    = 3'd6;

	localparam logic [1:0] STEP_HOUR = 2'd0;
	localparam logic [1:0] STEP_MIN  = 2'd1;
	localparam logic [1:0] STEP_SEC  = 2'd2;
	localparam logic [1:0] STEP_NSEC = 2'd3;

	logic [2:0]                        state_q;
	logic [1:0]                        step_q;
	logic                              stamp_q;
	logic                              ref_valid_q;
	logic [63:0]                       ref_epoch_q;
	logic [31:0]                       ref_dev_q;
	logic                              rsp_valid_q;
	utc_ets_pkg::rsp_t                 rsp_q;
	utc_ets_pkg::rsp_t                 res_q;
	utc_ets_pkg::req_t                 item_q;
	logic [utc_ets_pkg::YEAR_W-1:0]    year_q;
	logic [3:0]                        month_q;
	logic [utc_ets_pkg::YEAR_W-1:0]    y_q;
	logic [3:0]                        m_q;
	logic [1:0]                        c4_q;
	logic [6:0]                        c100_q;
	logic [8:0]                        c400_q;
	logic [DAYS_W-1:0]                 days_q;
	logic [63:0]                       acc_q;

	logic                              use_device_time;
	logic                              accept;
	logic                              out_free;
	logic                              leap;
	logic                              last_step;
	logic [utc_ets_pkg::YEAR_W-1:0]    year_c;
	logic [3:0]                        month_c;
	logic [8:0]                        year_len;
	logic [5:0]                        month_len;
	utc_ets_pkg::mac_req_t             mac_req;
	utc_ets_pkg::mac_rsp_t             mac_rsp;

	// Register port
	utc_ets_cfg u_cfg (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.use_device_time (use_device_time)
	);

	// Shared multiply-add unit
	utc_ets_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.mac_req (mac_req),
		.mac_rsp (mac_rsp)
	);

	// Handshakes
	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Clamp year and month of the incoming reference
	always_comb begin
		if (req.year < utc_ets_pkg::FIRST_YEAR_Y) begin
			year_c = utc_ets_pkg::FIRST_YEAR_Y;
		end else if (req.year > LAST_YEAR_Y) begin
			year_c = LAST_YEAR_Y;
		end else begin
			year_c = req.year;
		end
		if (req.month < utc_ets_pkg::MONTH_JAN) begin
			month_c = utc_ets_pkg::MONTH_JAN;
		end else if (req.month > utc_ets_pkg::MONTH_DEC) begin
			month_c = utc_ets_pkg::MONTH_DEC;
		end else begin
			month_c = req.month;
		end
	end

	// Leap test of the year under the walk counters
	assign leap     = ((c4_q == 2'd0) && (c100_q != 7'd0)) || (c400_q == 9'd0);
	assign year_len = leap ? utc_ets_pkg::DAYS_PER_LEAP : utc_ets_pkg::DAYS_PER_YEAR;
	assign month_len = {1'b0, utc_ets_pkg::month_days(m_q)}
		+ {5'd0, (m_q == utc_ets_pkg::MONTH_FEB) && leap};
	assign last_step = stamp_q ? (step_q == STEP_HOUR) : (step_q == STEP_NSEC);

	// Select factor and addend of the current chain step
	always_comb begin
		mac_req.start   = (state_q == ST_MACGO);
		mac_req.operand = acc_q;
		if (stamp_q) begin
			mac_req.factor = utc_ets_pkg::NS_PER_US;
			mac_req.addend = ref_epoch_q;
		end else begin
			case (step_q)
				STEP_HOUR: begin
					mac_req.factor = utc_ets_pkg::HOURS_PER_DAY;
					mac_req.addend = {59'd0, item_q.hour};
				end
				STEP_MIN: begin
					mac_req.factor = utc_ets_pkg::MIN_PER_HOUR;
					mac_req.addend = {58'd0, item_q.minute};
				end
				STEP_SEC: begin
					mac_req.factor = utc_ets_pkg::SEC_PER_MIN;
					mac_req.addend = {58'd0, item_q.second};
				end
				default: begin
					mac_req.factor = utc_ets_pkg::NS_PER_SEC;
					mac_req.addend = {34'd0, item_q.nanosecond};
				end
			endcase
		end
	end

	// Sequencer, reference state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= STEP_HOUR;
			stamp_q     <= 1'b0;
			ref_valid_q <= 1'b0;
			ref_epoch_q <= 64'd0;
			ref_dev_q   <= 32'd0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						step_q <= STEP_HOUR;
						if (req.req_type == utc_ets_pkg::REQ_STAMP) begin
							stamp_q <= 1'b1;
							if (ref_valid_q && use_device_time) begin
								state_q <= ST_MACGO;
							end else begin
								state_q <= ST_DONE;
							end
						end else begin
							stamp_q <= 1'b0;
							if (req.clock_valid) begin
								state_q <= ST_YEAR;
							end else begin
								state_q <= ST_DONE;
							end
						end
					end
				end
				ST_YEAR: begin
					if (y_q == year_q) begin
						state_q <= ST_MONTH;
					end
				end
				ST_MONTH: begin
					if (m_q == month_q) begin
						state_q <= ST_DAYADD;
					end
				end
				ST_DAYADD: state_q <= ST_MACGO;
				ST_MACGO:  state_q <= ST_MACWAIT;
				ST_MACWAIT: begin
					if (mac_rsp.done) begin
						if (last_step) begin
							state_q <= ST_DONE;
							if (!stamp_q) begin
								ref_valid_q <= 1'b1;
								ref_epoch_q <= mac_rsp.result;
								ref_dev_q   <= item_q.dev_time_us;
							end
						end else begin
							step_q  <= step_q + 2'd1;
							state_q <= ST_MACGO;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Walk counters, accumulator and result registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					item_q  <= req;
					year_q  <= year_c;
					month_q <= month_c;
					y_q     <= utc_ets_pkg::FIRST_YEAR_Y;
					m_q     <= utc_ets_pkg::MONTH_JAN;
					c4_q    <= utc_ets_pkg::FIRST_MOD4;
					c100_q  <= utc_ets_pkg::FIRST_MOD100;
					c400_q  <= utc_ets_pkg::FIRST_MOD400;
					days_q  <= '0;
					acc_q   <= {32'd0, req.dev_time_us - ref_dev_q};
					res_q.epoch_ns    <= 64'd0;
					res_q.stamp_valid <= 1'b0;
					res_q.utc_error   <= (req.req_type == utc_ets_pkg::REQ_UTC)
						&& !req.clock_valid;
				end
			end
			ST_YEAR: begin
				if (y_q != year_q) begin
					days_q <= days_q + DAYS_W'(year_len);
					y_q    <= y_q + 12'd1;
					c4_q   <= c4_q + 2'd1;
					c100_q <= (c100_q == utc_ets_pkg::LAST_MOD100) ? 7'd0 : c100_q + 7'd1;
					c400_q <= (c400_q == utc_ets_pkg::LAST_MOD400) ? 9'd0 : c400_q + 9'd1;
				end
			end
			ST_MONTH: begin
				if (m_q != month_q) begin
					days_q <= days_q + DAYS_W'(month_len);
					m_q    <= m_q + 4'd1;
				end
			end
			ST_DAYADD: begin
				acc_q <= 64'(days_q) + {59'd0, item_q.day} - 64'd1;
			end
			ST_MACWAIT: begin
				if (mac_rsp.done) begin
					acc_q <= mac_rsp.result;
					if (last_step) begin
						res_q.epoch_ns    <= mac_rsp.result;
						res_q.stamp_valid <= 1'b1;
						res_q.utc_error   <= 1'b0;
					end
				end
			end
			ST_DONE: begin
				if (out_free) begin
					rsp_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	// The multiply-add unit only finishes while the sequencer waits for it
	a_mac_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mac_rsp.done |-> (state_q == ST_MACWAIT))
		else $error("multiply-add finished outside its wait state");

	// A stored reference is never dropped
	a_ref_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(ref_valid_q))
		else $error("reference valid dropped");

	// A rejected reference carries no time
	a_err_result: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.utc_error) |-> (!rsp.stamp_valid && (rsp.epoch_ns == 64'd0)))
		else $error("error result carries a time");

	// The walks never pass their targets
	a_year_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_YEAR) |-> (y_q <= year_q))
		else $error("year walk passed the target year");

	a_month_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MONTH) |-> (m_q <= month_q))
		else $error("month walk passed the target month");

endmodule

[hdl/utc_ets_cfg.sv]
// ----------------------------------------------------------------------------
// UTC epoch timestamp converter register port
// APB register file holding the device time select bit.
// ----------------------------------------------------------------------------
module utc_ets_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [utc_ets_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	output logic                             use_device_time
);

	logic use_device_time_q;
	logic wr_en;

	// Decode a completed write to the select register
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite
		&& (paddr[2] == utc_ets_pkg::REG_IDX_USE_DEVICE_TIME);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_device_time_q <= 1'b0;
		end else if (wr_en) begin
			use_device_time_q <= pwdata[0];
		end
	end

	// Return the register, zero elsewhere
	always_comb begin
		if (paddr[2] == utc_ets_pkg::REG_IDX_USE_DEVICE_TIME) begin
			prdata = {31'd0, use_device_time_q};
		end else begin
			prdata = 32'd0;
		end
	end

	assign use_device_time = use_device_time_q;

endmodule

[hdl/utc_ets_mac.sv]
// ----------------------------------------------------------------------------
// UTC epoch timestamp converter multiply-add unit
// Computes operand * factor + addend modulo 2^64 on one shared 32x30
// multiplier: low half, high half, then the sum.
// ----------------------------------------------------------------------------
module utc_ets_mac (
	input  logic                  clk,
	input  logic                  arst_n,
	input  utc_ets_pkg::mac_req_t mac_req,
	output utc_ets_pkg::mac_rsp_t mac_rsp
);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_LO   = 2'd1;
	localparam logic [1:0] PH_HI   = 2'd2;
	localparam logic [1:0] PH_SUM  = 2'd3;

	logic [1:0]                           phase_q;
	logic                                 done_q;
	logic [63:0]                          a_q;
	logic [utc_ets_pkg::FACTOR_W-1:0]     k_q;
	logic [63:0]                          add_q;
	logic [61:0]                          p_lo_q;
	logic [31:0]                          p_hi_q;
	logic [63:0]                          result_q;
	logic [31:0]                          mul_op;
	logic [61:0]                          prod;

	// Shared multiplier, operand half chosen by phase
	assign mul_op = (phase_q == PH_HI) ? a_q[63:32] : a_q[31:0];
	assign prod   = {30'd0, mul_op} * {32'd0, k_q};

	// Advance the phase and raise done for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				PH_IDLE: begin
					if (mac_req.start) begin
						phase_q <= PH_LO;
					end
				end
				PH_LO:   phase_q <= PH_HI;
				PH_HI:   phase_q <= PH_SUM;
				PH_SUM: begin
					phase_q <= PH_IDLE;
					done_q  <= 1'b1;
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	// Hold operands and partial products
	always_ff @(posedge clk) begin
		if (phase_q == PH_IDLE && mac_req.start) begin
			a_q   <= mac_req.operand;
			k_q   <= mac_req.factor;
			add_q <= mac_req.addend;
		end
		if (phase_q == PH_LO) begin
			p_lo_q <= prod;
		end
		if (phase_q == PH_HI) begin
			p_hi_q <= prod[31:0];
		end
		if (phase_q == PH_SUM) begin
			result_q <= {2'd0, p_lo_q} + {p_hi_q, 32'd0} + add_q;
		end
	end

	assign mac_rsp.done   = done_q;
	assign mac_rsp.result = result_q;

endmodule
